### rtl/decimal_big_digit_renderer_macros.svh
// -----------------------------------------------------------------------------
// decimal_big_digit_renderer_macros.svh
// Assertion helpers shared by the renderer RTL. They expect clk and rst in scope.
// -----------------------------------------------------------------------------
`ifndef DECIMAL_BIG_DIGIT_RENDERER_MACROS_SVH
`define DECIMAL_BIG_DIGIT_RENDERER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DBDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DBDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dbdr_pkg.sv
// -----------------------------------------------------------------------------
// dbdr_pkg
// Widths, font glyphs, state types and status structs for the big digit renderer.
// -----------------------------------------------------------------------------
package dbdr_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 7;

  localparam int VALUE_W   = 31;
  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = MAX_DIGITS * DIGIT_W;
  localparam int ROW_W     = 3;
  localparam int CNT_W     = 4;
  localparam int HALF_SLOT = 5;
  localparam int HALF_W    = HALF_SLOT * GLYPH_COLS;
  localparam int BITCNT_W  = $clog2(VALUE_W);
  localparam int FONT_N    = 10 * GLYPH_ROWS;
  localparam int FONT_AW   = $clog2(FONT_N);

  // Glyphs for digits 0..9, seven rows each, leftmost pixel in the MSB
  localparam logic [GLYPH_COLS-1:0] FONT_ROM [0:FONT_N-1] = '{
    7'h1C, 7'h22, 7'h22, 7'h22, 7'h22, 7'h22, 7'h1C,
    7'h18, 7'h38, 7'h78, 7'h18, 7'h18, 7'h18, 7'h7E,
    7'h3C, 7'h42, 7'h04, 7'h04, 7'h08, 7'h10, 7'h7E,
    7'h3C, 7'h46, 7'h06, 7'h7C, 7'h06, 7'h46, 7'h3C,
    7'h0C, 7'h14, 7'h24, 7'h7E, 7'h04, 7'h04, 7'h04,
    7'h7E, 7'h40, 7'h40, 7'h3C, 7'h02, 7'h02, 7'h7C,
    7'h3E, 7'h40, 7'h40, 7'h7C, 7'h42, 7'h42, 7'h3C,
    7'h7E, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40,
    7'h1C, 7'h22, 7'h22, 7'h1C, 7'h22, 7'h22, 7'h1C,
    7'h1C, 7'h22, 7'h22, 7'h1E, 7'h02, 7'h22, 7'h1C
  };

  // One glyph row lookup; non-decimal codes render blank
  function automatic logic [GLYPH_COLS-1:0] font_bits(input logic [DIGIT_W-1:0] d,
                                                      input logic [ROW_W-1:0] r);
    logic [FONT_AW-1:0] idx;
    idx = FONT_AW'(d) * FONT_AW'(GLYPH_ROWS) + FONT_AW'(r);
    if (d > DIGIT_W'(9)) begin
      font_bits = '0;
    end else begin
      font_bits = FONT_ROM[idx];
    end
  endfunction

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_NORM
  } conv_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CONV,
    T_ROWS
  } top_state_t;

  // Converter status toward the sequencer
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] digit_count;
  } conv_stat_t;

endpackage

### rtl/dbdr_ifs.sv
// -----------------------------------------------------------------------------
// dbdr_ifs
// Valid/ready channel interfaces for the input value and the rendered rows.
// -----------------------------------------------------------------------------
interface dbdr_in_if;
  import dbdr_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dbdr_out_if;
  import dbdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_index;
  logic [CNT_W-1:0]  digit_count;
  logic [HALF_W-1:0] pixels_left;
  logic [HALF_W-1:0] pixels_right;
  logic              last;

  modport source (output valid, output row_index, output digit_count,
                  output pixels_left, output pixels_right, output last,
                  input ready);
  modport sink   (input valid, input row_index, input digit_count,
                  input pixels_left, input pixels_right, input last,
                  output ready);
endinterface

### rtl/dbdr_convert.sv
// -----------------------------------------------------------------------------
// dbdr_convert
// Bit-serial binary to BCD (shift and add-3), then left-justifies the digits.
// -----------------------------------------------------------------------------
module dbdr_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dbdr_pkg::VALUE_W-1:0]  value,
  output dbdr_pkg::conv_stat_t          stat,
  output logic [dbdr_pkg::BCD_W-1:0]    bcd
);
  import dbdr_pkg::*;

  conv_state_t         state, state_next;
  logic [VALUE_W-1:0]  shreg;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]    count;
  logic [BCD_W-1:0]    bcd_adj;
  logic                last_bit;
  logic                norm_done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign last_bit  = (bit_cnt == BITCNT_W'(VALUE_W - 1));
  // stop once the top digit is nonzero, or no digits remain (zero input)
  assign norm_done = (count == '0) || (bcd[BCD_W-1 -: DIGIT_W] != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:  if (start) state_next = C_SHIFT;
      C_SHIFT: if (last_bit) state_next = C_NORM;
      C_NORM:  if (norm_done) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.done        = (state == C_NORM) && norm_done;
    stat.digit_count = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          shreg   <= value;
          bcd     <= '0;
          bit_cnt <= '0;
          count   <= CNT_W'(MAX_DIGITS);
        end
      end
      C_SHIFT: begin
        bcd     <= {bcd_adj[BCD_W-2:0], shreg[VALUE_W-1]};
        shreg   <= {shreg[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BITCNT_W'(1);
      end
      C_NORM: begin
        if (!norm_done) begin
          bcd   <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          count <= count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/decimal_big_digit_renderer.sv
// -----------------------------------------------------------------------------
// decimal_big_digit_renderer: large decimal digit row generator
// Flow: the converter turns each accepted value into BCD and left-justifies the digits,
// then the rows follow at one row per cycle while the output sink is ready.
// A new value is accepted only once all 7 row transactions of the last are loaded.
// Reset: synchronous active-high rst idles both sequencers and drops out valid.
// -----------------------------------------------------------------------------
`include "decimal_big_digit_renderer_macros.svh"

module decimal_big_digit_renderer (
  input  logic       clk,
  input  logic       rst,
  dbdr_in_if.sink    in_ch,
  dbdr_out_if.source out_ch
);
  import dbdr_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  top_state_t         state, state_next;
  logic               conv_start;
  conv_stat_t         conv_stat;
  logic [BCD_W-1:0]   bcd;
  logic [ROW_W-1:0]   row;
  logic               row_load;
  logic               out_valid;
  logic [ROW_W-1:0]   out_row;
  logic [CNT_W-1:0]   out_count;
  logic [2*HALF_W-1:0] out_px;
  logic               out_last;
  logic [2*HALF_W-1:0] row_px;

  dbdr_convert u_convert (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (in_ch.value),
    .stat  (conv_stat),
    .bcd   (bcd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (in_ch.valid) state_next = T_CONV;
      T_CONV:  if (conv_stat.done) state_next = T_ROWS;
      T_ROWS:  if (row_load && (row == LAST_ROW)) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state == T_IDLE);
    conv_start  = (state == T_IDLE) && in_ch.valid;
    row_load    = (state == T_ROWS) && (!out_valid || out_ch.ready);
  end

  // glyph slices for the current row, blank past the digit count
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < conv_stat.digit_count) begin
        row_px[2*HALF_W-1-i*GLYPH_COLS -: GLYPH_COLS] =
          font_bits(bcd[BCD_W-1-i*DIGIT_W -: DIGIT_W], row);
      end else begin
        row_px[2*HALF_W-1-i*GLYPH_COLS -: GLYPH_COLS] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      row       <= '0;
    end else begin
      state <= state_next;
      if (row_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (state == T_CONV) begin
        row <= '0;
      end else if (row_load) begin
        row <= row + ROW_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (row_load) begin
      out_row   <= row;
      out_count <= conv_stat.digit_count;
      out_px    <= row_px;
      out_last  <= (row == LAST_ROW);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.row_index    = out_row;
  assign out_ch.digit_count  = out_count;
  assign out_ch.pixels_left  = out_px[2*HALF_W-1:HALF_W];
  assign out_ch.pixels_right = out_px[HALF_W-1:0];
  assign out_ch.last         = out_last;

  // checks
  `DBDR_ASSERT_NOW(a_done_in_conv, conv_stat.done, state == T_CONV, "conversion done outside CONV")
  `DBDR_ASSERT_NOW(a_last_row, out_ch.valid && out_ch.last, out_ch.row_index == LAST_ROW, "last flag on wrong row")
  `DBDR_ASSERT_NOW(a_count_max, out_ch.valid, out_ch.digit_count <= CNT_W'(MAX_DIGITS), "digit count too large")
  `DBDR_ASSERT_NEXT(a_rows_burst, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid, "gap inside row burst")

endmodule
